// ----- src/assert_macros.svh -----
// Assertion macros shared by the hash set RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LPHS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("lphs: implication check failed");

// Next-cycle implication, disabled while reset is low.
`define LPHS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("lphs: next-cycle check failed");

`endif

// ----- src/lphs_pkg.sv -----
// Package for the linear probing hash set: item types, codes and the
// controller/datapath command and status structs. No dependencies.
package lphs_pkg;

  localparam int unsigned TABLE_SIZE = 1024;
  localparam int unsigned KEY_W      = 31;
  localparam int unsigned HASH_W     = 32;
  localparam int unsigned ENTRY_W    = 11;

  localparam logic [ENTRY_W-1:0] MAX_ENTRIES_RESET = 11'd512;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_DUP       = 2'd3
  } status_t;

  typedef struct packed {
    kind_t               kind;
    logic [KEY_W-1:0]    key;
    logic [HASH_W-1:0]   hash_value;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [KEY_W-1:0]    found_key;
    logic [ENTRY_W-1:0]  entry_count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic    accept;       // latch input item, start probe
    logic    sweep;        // empty slot at idx, idx++
    logic    clear_count;  // occupancy to zero
    logic    rd;           // read slot at idx
    logic    step;         // probe next slot down, count probe
    logic    scan_step;    // delete scan: next slot down
    logic    ins_write;    // store key at idx, occupancy++
    logic    hole_clear;   // empty slot at idx, it becomes the hole
    logic    move;         // copy read entry into hole
    logic    dec;          // occupancy--
    logic    cap_found;    // keep read key as found key
    logic    set_status;
    status_t status_code;
    logic    fin;          // load output register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_t kind;
    logic  probe_done;
    logic  slot_valid;
    logic  key_hit;
    logic  table_full;
    logic  table_empty;
    logic  shift_ok;
    logic  sweep_last;
    logic  out_free;
  } dp_status_t;

endpackage

// ----- src/lphs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lphs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/lphs_dp.sv -----
// Datapath of the hash set: slot RAM, probe/hole indices, occupancy,
// limit register and output register. Uses lphs_pkg and lphs_ram.
module lphs_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lphs_pkg::in_item_t                  in_data,
  input  logic                                cfg_valid,
  input  logic [lphs_pkg::ENTRY_W-1:0]        cfg_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output lphs_pkg::out_item_t                 out_data,
  input  lphs_pkg::ctl_cmd_t                  cmd,
  output lphs_pkg::dp_status_t                st
);

  localparam int unsigned TABLE_SIZE = lphs_pkg::TABLE_SIZE;
  localparam int unsigned IDX_W  = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned KEY_W  = lphs_pkg::KEY_W;
  localparam int unsigned WORD_W = 1 + IDX_W + KEY_W;
  localparam int unsigned ENT_W  = lphs_pkg::ENTRY_W;
  localparam int unsigned CMP_W  = (CNT_W > ENT_W) ? CNT_W : ENT_W;
  localparam logic [CNT_W-1:0] TS = CNT_W'(TABLE_SIZE);

  lphs_pkg::kind_t     kind_r;
  logic [KEY_W-1:0]    key_r;
  logic [IDX_W-1:0]    home_r;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    hole_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ENT_W-1:0]    max_r;
  lphs_pkg::status_t   status_r;
  logic [KEY_W-1:0]    found_r;
  logic                out_valid_r;
  lphs_pkg::out_item_t out_data_r;

  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [WORD_W-1:0]   wdata;
  logic [WORD_W-1:0]   rdata;
  logic                rd_valid;
  logic [IDX_W-1:0]    rd_home;
  logic [KEY_W-1:0]    rd_key;

  lphs_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_SIZE)) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign rd_valid = rdata[WORD_W-1];
  assign rd_home  = rdata[KEY_W +: IDX_W];
  assign rd_key   = rdata[KEY_W-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = '0;
    if (cmd.ins_write) begin
      we    = 1'b1;
      wdata = {1'b1, home_r, key_r};
    end else if (cmd.move) begin
      we    = 1'b1;
      waddr = hole_r;
      wdata = rdata;
    end else if (cmd.sweep || cmd.hole_clear) begin
      we    = 1'b1;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.accept) begin
      idx_nxt = (in_data.kind == lphs_pkg::KIND_CLEAR) ? '0 : in_data.hash_value[IDX_W-1:0];
    end else if (cmd.sweep) begin
      idx_nxt = idx_r + 1'b1;
    end else if (cmd.step || cmd.scan_step || cmd.hole_clear) begin
      idx_nxt = idx_r - 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear_count) begin
      count_nxt = '0;
    end else if (cmd.ins_write) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.dec) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      count_r     <= '0;
      max_r       <= lphs_pkg::MAX_ENTRIES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      if (cfg_valid) begin
        max_r <= cfg_data;
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_data.kind;
      key_r  <= in_data.key;
      home_r <= in_data.hash_value[IDX_W-1:0];
    end
    if (cmd.accept) begin
      cnt_r <= '0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.hole_clear) begin
      hole_r <= idx_r;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end else if (cmd.accept) begin
      status_r <= lphs_pkg::ST_OK;
    end
    if (cmd.accept) begin
      found_r <= '0;
    end else if (cmd.cap_found) begin
      found_r <= rd_key;
    end
    if (cmd.fin) begin
      out_data_r.status      <= status_r;
      out_data_r.found_key   <= found_r;
      out_data_r.entry_count <= ENT_W'(count_r);
    end
  end

  // Algorithm R: entry at idx may fill the hole unless its home lies
  // cyclically between the hole and idx.
  always_comb begin
    st.kind        = kind_r;
    st.probe_done  = (cnt_r == TS);
    st.slot_valid  = rd_valid;
    st.key_hit     = (rd_key == key_r);
    st.table_full  = (CMP_W'(count_r) >= CMP_W'(max_r)) || (count_r >= TS);
    st.table_empty = (count_r == '0);
    st.shift_ok    = ((rd_home < idx_r) && ((idx_r <= hole_r) || (hole_r <= rd_home))) ||
                     ((idx_r <= hole_r) && (hole_r <= rd_home));
    st.sweep_last  = (idx_r == {IDX_W{1'b1}});
    st.out_free    = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/lphs_ctrl.sv -----
// Controller state machine of the hash set: sequences probes, inserts,
// backward-shift deletes and clear sweeps. Uses lphs_pkg.
module lphs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  lphs_pkg::kind_t       in_kind,
  output logic                  in_stall,
  input  lphs_pkg::dp_status_t  st,
  output lphs_pkg::ctl_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CLEAR = 9'b000000100,
    S_RD    = 9'b000001000,
    S_CHK   = 9'b000010000,
    S_HOLE  = 9'b000100000,
    S_DRD   = 9'b001000000,
    S_DCHK  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.status_code = lphs_pkg::ST_OK;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT, S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (st.sweep_last) begin
          cmd.clear_count = 1'b1;
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_kind == lphs_pkg::KIND_CLEAR) begin
            state_nxt = S_CLEAR;
          end else if (in_kind == lphs_pkg::KIND_DELETE && st.table_empty) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = lphs_pkg::ST_NOT_FOUND;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        if (st.probe_done) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = (st.kind == lphs_pkg::KIND_INSERT) ? lphs_pkg::ST_FULL
                                                                : lphs_pkg::ST_NOT_FOUND;
          state_nxt = S_DONE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (!st.slot_valid) begin
          state_nxt = S_DONE;
          if (st.kind == lphs_pkg::KIND_INSERT) begin
            if (st.table_full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = lphs_pkg::ST_FULL;
            end else begin
              cmd.ins_write = 1'b1;
            end
          end else begin
            cmd.set_status  = 1'b1;
            cmd.status_code = lphs_pkg::ST_NOT_FOUND;
          end
        end else if (st.key_hit) begin
          if (st.kind == lphs_pkg::KIND_INSERT) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = lphs_pkg::ST_DUP;
            state_nxt = S_DONE;
          end else if (st.kind == lphs_pkg::KIND_DELETE) begin
            cmd.cap_found = 1'b1;
            cmd.dec       = 1'b1;
            state_nxt = S_HOLE;
          end else begin
            cmd.cap_found = 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_HOLE: begin
        cmd.hole_clear = 1'b1;
        state_nxt = S_DRD;
      end
      S_DRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_DCHK;
      end
      S_DCHK: begin
        if (!st.slot_valid) begin
          state_nxt = S_DONE;
        end else if (st.shift_ok) begin
          cmd.move  = 1'b1;
          state_nxt = S_HOLE;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt = S_DRD;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/linear_probe_hash_set.sv -----
// Top level of the linear probing hash set: controller plus datapath.
// Depends on lphs_pkg, lphs_ctrl, lphs_dp (and lphs_ram below it) and assert_macros.svh.
//
//   port group  | direction | handshake        | payload
//   in_         | to block  | in_valid/in_stall  | lphs_pkg::in_item_t
//   out_        | from block| out_valid/out_stall| lphs_pkg::out_item_t
//   cfg_        | to block  | cfg_valid/cfg_ready| max_entries, 11 bits
//
// Each probed slot is read (S_RD) and then checked (S_CHK), since the
// single-read-port slot RAM registers its read data; a run of TABLE_SIZE
// probes ends in S_RD with no read. A delete then clears the hole (S_HOLE)
// and reads and checks slots below it (S_DRD, S_DCHK), each moved entry
// leaving a new hole. Clear and reset both sweep the slot RAM, in_stall high.
// A finished result sits in the output register; the next item is taken
// while it waits, and only the following result stalls behind out_stall.
module linear_probe_hash_set (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lphs_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lphs_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lphs_pkg::ENTRY_W-1:0]  cfg_data
);

`include "assert_macros.svh"

  lphs_pkg::ctl_cmd_t   cmd;
  lphs_pkg::dp_status_t st;

  // limit register takes a write in any cycle
  assign cfg_ready = 1'b1;

  lphs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  lphs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

  // an accepted item always keeps the block busy in the cycle after it is taken
  `LPHS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // only successful lookups and deletes report a key
  `LPHS_ASSERT_IMP(a_found_only_ok, clk, rst_n,
    out_valid && (out_data.status != lphs_pkg::ST_OK), out_data.found_key == '0)
  // occupancy never exceeds the slot count
  `LPHS_ASSERT_IMP(a_count_bound, clk, rst_n, out_valid,
    32'(out_data.entry_count) <= 32'(lphs_pkg::TABLE_SIZE))

endmodule

// ----- bench/tb.sv -----
// Testbench for linear_probe_hash_set: random and directed set operations
// checked against an in-bench model of the probing table. Depends on lphs_pkg.
module tb;

  localparam int unsigned TBL = lphs_pkg::TABLE_SIZE;
  localparam int unsigned KW = lphs_pkg::KEY_W;
  localparam int unsigned SWEEP_WAIT = 3000;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lphs_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lphs_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lphs_pkg::ENTRY_W-1:0] cfg_data = '0;
  logic in_taken = 1'b0;

  linear_probe_hash_set u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table
  logic                         shadow_valid [TBL];
  logic [KW-1:0]                shadow_key   [TBL];
  logic [9:0]                   shadow_home  [TBL];
  int unsigned                  shadow_count;
  logic [lphs_pkg::ENTRY_W-1:0] limit_reg;

  lphs_pkg::in_item_t  pending_items[$];
  lphs_pkg::out_item_t expected_results[$];
  logic [KW-1:0] used_keys[$];   // keys drawn so far, reused for hits

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  failed = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  longint unsigned cycles = 0;

  function automatic int unsigned slot_below(int unsigned j);
    return (j == 0) ? TBL - 1 : j - 1;
  endfunction

  function automatic int unsigned locate_key(logic [KW-1:0] k, int unsigned home);
    int unsigned j;
    j = home;
    for (int n = 0; n < TBL; n++) begin
      if (!shadow_valid[j]) break;
      if (shadow_key[j] == k) return j;
      j = slot_below(j);
    end
    return TBL;
  endfunction

  // Backward-shift delete: empty the hole and pull later chain members back.
  function automatic void erase_slot(int unsigned hole);
    int unsigned j, h;
    bit moved;
    shadow_valid[hole] = 1'b0;
    for (int r = 0; r < TBL; r++) begin
      j = hole;
      moved = 0;
      for (int n = 0; n < TBL; n++) begin
        j = slot_below(j);
        if (!shadow_valid[j]) return;
        h = {22'd0, shadow_home[j]};
        if ((h < j && (j <= hole || hole <= h)) || (j <= hole && hole <= h)) begin
          shadow_key[hole] = shadow_key[j];
          shadow_home[hole] = h[9:0];
          shadow_valid[hole] = 1'b1;
          shadow_valid[j] = 1'b0;
          hole = j;
          moved = 1;
          break;
        end
      end
      if (!moved) return;
    end
  endfunction

  function automatic lphs_pkg::out_item_t apply_op(lphs_pkg::in_item_t it);
    lphs_pkg::out_item_t r;
    int unsigned home, s, j;
    home = it.hash_value % TBL;
    r = '0;
    r.status = lphs_pkg::ST_OK;
    case (it.kind)
      lphs_pkg::KIND_LOOKUP: begin
        s = locate_key(it.key, home);
        if (s < TBL) r.found_key = shadow_key[s];
        else r.status = lphs_pkg::ST_NOT_FOUND;
      end
      lphs_pkg::KIND_INSERT: begin
        if (locate_key(it.key, home) < TBL) r.status = lphs_pkg::ST_DUP;
        else if (shadow_count >= limit_reg || shadow_count >= TBL)
          r.status = lphs_pkg::ST_FULL;
        else begin
          j = home;
          for (int n = 0; n < TBL && shadow_valid[j]; n++) j = slot_below(j);
          if (shadow_valid[j]) r.status = lphs_pkg::ST_FULL;
          else begin
            shadow_valid[j] = 1'b1;
            shadow_key[j] = it.key;
            shadow_home[j] = home[9:0];
            shadow_count++;
          end
        end
      end
      lphs_pkg::KIND_DELETE: begin
        s = (shadow_count != 0) ? locate_key(it.key, home) : TBL;
        if (s < TBL) begin
          r.found_key = shadow_key[s];
          erase_slot(s);
          shadow_count--;
        end else r.status = lphs_pkg::ST_NOT_FOUND;
      end
      default: begin
        for (int i = 0; i < TBL; i++) shadow_valid[i] = 1'b0;
        shadow_count = 0;
      end
    endcase
    r.entry_count = shadow_count[lphs_pkg::ENTRY_W-1:0];
    return r;
  endfunction

  // Driver: one item per handshake, changes on the falling edge. in_taken
  // marks that the item on the port went in at the last rising edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        expected_results.push_back(apply_op(in_data));
        items_sent++;
        void'(pending_items.pop_front());
      end
      if (!in_valid || in_taken) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_items[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("unexpected result %p", out_data);
        failed = 1;
      end else begin
        lphs_pkg::out_item_t e;
        e = expected_results.pop_front();
        if (out_data.status !== e.status) begin
          $error("status: expected %0d got %0d", e.status, out_data.status);
          failed = 1;
        end
        if (out_data.found_key !== e.found_key) begin
          $error("found_key: expected %0h got %0h", e.found_key, out_data.found_key);
          failed = 1;
        end
        if (out_data.entry_count !== e.entry_count) begin
          $error("entry_count: expected %0d got %0d", e.entry_count, out_data.entry_count);
          failed = 1;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb failed");
      $finish;
    end
  end

  function automatic lphs_pkg::in_item_t make_item(lphs_pkg::kind_t k, logic [KW-1:0] key,
                                                   logic [lphs_pkg::HASH_W-1:0] h);
    lphs_pkg::in_item_t it;
    it.kind = k;
    it.key = key;
    it.hash_value = h;
    return it;
  endfunction

  // Hash derived from key so repeated keys share a home; the high bits of the
  // hash carry further key bits that the block must ignore. Narrow homes crowd
  // clusters together, including wraparound at slot zero.
  function automatic logic [lphs_pkg::HASH_W-1:0] hash_of(logic [KW-1:0] key,
                                                          int unsigned spread);
    logic [lphs_pkg::HASH_W-1:0] h;
    h = {key[21:0] ^ key[30:9], 10'd0} | ((key * 32'd2654435761) % spread);
    if (key[0]) h[9:0] = 10'(TBL - 1 - h[9:0]);
    return h;
  endfunction

  task automatic add_random(int count, int unsigned spread, int key_span);
    lphs_pkg::in_item_t it;
    logic [KW-1:0] k;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (used_keys.size() != 0 && $urandom_range(99) < 55)
        k = used_keys[$urandom_range(used_keys.size() - 1)];
      else begin
        k = (key_span == 0) ? KW'($urandom()) : KW'($urandom_range(key_span));
        used_keys.push_back(k);
      end
      if (sel < 45) it = make_item(lphs_pkg::KIND_INSERT, k, hash_of(k, spread));
      else if (sel < 70) it = make_item(lphs_pkg::KIND_LOOKUP, k, hash_of(k, spread));
      else if (sel < 97) it = make_item(lphs_pkg::KIND_DELETE, k, hash_of(k, spread));
      else if (sel < 98) it = make_item(lphs_pkg::KIND_CLEAR, KW'($urandom()), $urandom());
      else it = make_item(lphs_pkg::kind_t'($urandom_range(2)), KW'($urandom()), $urandom());
      pending_items.push_back(it);
    end
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SWEEP_WAIT) @(posedge clk);
  endtask

  task automatic write_limit(logic [lphs_pkg::ENTRY_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < TBL; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_home[i] = '0;
    end
    shadow_count = 0;
    limit_reg = lphs_pkg::MAX_ENTRIES_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (SWEEP_WAIT) @(posedge clk);

    // Directed: empty-table cases, extremes, duplicate, wraparound chains.
    pending_items.push_back(make_item(lphs_pkg::KIND_DELETE, 31'd5, 32'd5));
    pending_items.push_back(make_item(lphs_pkg::KIND_LOOKUP, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(lphs_pkg::KIND_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(lphs_pkg::KIND_INSERT, 31'd0, 32'd0));
    pending_items.push_back(make_item(lphs_pkg::KIND_INSERT, 31'd0, 32'd0));
    pending_items.push_back(make_item(lphs_pkg::KIND_INSERT, 31'd1, 32'hFFFF_FC00));
    pending_items.push_back(make_item(lphs_pkg::KIND_INSERT, 31'd2, 32'd0));
    pending_items.push_back(make_item(lphs_pkg::KIND_INSERT, 31'd3, 32'd1023));
    pending_items.push_back(make_item(lphs_pkg::KIND_LOOKUP, 31'd2, 32'd0));
    pending_items.push_back(make_item(lphs_pkg::KIND_DELETE, 31'd0, 32'd0));
    pending_items.push_back(make_item(lphs_pkg::KIND_LOOKUP, 31'd2, 32'd0));
    pending_items.push_back(make_item(lphs_pkg::KIND_LOOKUP, 31'd1, 32'd0));
    pending_items.push_back(make_item(lphs_pkg::KIND_DELETE, 31'h7FFF_FFFF, 32'h0000_03FF));
    pending_items.push_back(make_item(lphs_pkg::KIND_LOOKUP, 31'd3, 32'd1023));
    pending_items.push_back(make_item(lphs_pkg::KIND_DELETE, 31'd77, 32'd0));
    pending_items.push_back(make_item(lphs_pkg::KIND_CLEAR, 31'h5555_5555, 32'hAAAA_AAAA));
    pending_items.push_back(make_item(lphs_pkg::KIND_LOOKUP, 31'd2, 32'd0));
    drain();

    // Zero limit refuses every insert; then limit of one.
    write_limit(11'd0);
    pending_items.push_back(make_item(lphs_pkg::KIND_INSERT, 31'd9, 32'd9));
    drain();
    write_limit(11'd1);
    pending_items.push_back(make_item(lphs_pkg::KIND_INSERT, 31'd9, 32'd9));
    pending_items.push_back(make_item(lphs_pkg::KIND_INSERT, 31'd10, 32'd9));
    pending_items.push_back(make_item(lphs_pkg::KIND_INSERT, 31'd9, 32'd9));
    pending_items.push_back(make_item(lphs_pkg::KIND_CLEAR, 31'd0, 32'd0));
    drain();

    // Random phases with differing idling and limits.
    write_limit(11'd16);
    add_random(160, 24, 40);
    drain();
    send_idle_pct = 70;
    write_limit(11'd1024);
    add_random(160, 64, 200);
    // Pause until every expected result is back, then keep going.
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 70;
    write_limit(11'd2047);
    add_random(160, 32, 100);
    drain();
    send_idle_pct = 31;
    recv_stall_pct = 31;
    write_limit(lphs_pkg::MAX_ENTRIES_RESET);
    add_random(160, 1024, 0);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_limit(11'd40);
    add_random(160, 16, 60);
    drain();

    $display("ran %0d items, %0d results checked, limits 0 to 2047", items_sent,
             results_seen);
    $display("lookup, insert, delete with chain repair, clear, full and duplicate");
    if (!failed && expected_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
